FILE: hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int NORM_W = 16;
  localparam int LANES  = 3;

endpackage

FILE: hdl/tun_if.sv
// ----------------------------------------------------------------------------
// tun_in_if / tun_out_if
// Valid/ready channels for triangle corners in and unit normals out.
// ----------------------------------------------------------------------------
interface tun_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  logic signed [CW-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tun_out_if;
  import tun_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic                     degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: hdl/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, squared length and root search seed values.
// ----------------------------------------------------------------------------
module tun_front import tun_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tun_in_if.sink               in_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [4*CW+2*FB+8:0] r_o [LANES],
  output logic signed [4*CW+2*FB+8:0] p_o [LANES],
  output logic signed [4*CW+2*FB+8:0] s_o,
  output logic                 neg_o [LANES],
  output logic                 deg_o
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int NW  = 2 * CW + 3;
  localparam int MW  = 2 * CW + 2;
  localparam int SQW = 4 * CW + 4;
  localparam int SW  = 4 * CW + 6;
  localparam int RW  = 4 * CW + 2 * FB + 9;
  localparam int NST = 6;

  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;

  logic signed [DW-1:0]  u_q [LANES];
  logic signed [DW-1:0]  v_q [LANES];
  logic signed [PW-1:0]  pr_q [6];
  logic        [MW-1:0]  mag_q [LANES];
  logic                  neg3_q [LANES];
  logic        [SQW-1:0] sq_q [LANES];
  logic                  neg4_q [LANES];
  logic        [SW-1:0]  sum_q;
  logic        [SQW-1:0] sq5_q [LANES];
  logic                  neg5_q [LANES];
  logic signed [RW-1:0]  r_q [LANES];
  logic signed [RW-1:0]  p_q [LANES];
  logic signed [RW-1:0]  s_q;
  logic                  neg6_q [LANES];
  logic                  deg_q;

  logic signed [NW-1:0]  n_d [LANES];

  always_comb begin
    rdy[NST] = ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_comb begin
    n_d[0] = NW'(pr_q[0]) - NW'(pr_q[1]);
    n_d[1] = NW'(pr_q[2]) - NW'(pr_q[3]);
    n_d[2] = NW'(pr_q[4]) - NW'(pr_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_i.valid) begin
      u_q[0] <= DW'(in_i.c_x) - DW'(in_i.a_x);
      u_q[1] <= DW'(in_i.c_y) - DW'(in_i.a_y);
      u_q[2] <= DW'(in_i.c_z) - DW'(in_i.a_z);
      v_q[0] <= DW'(in_i.b_x) - DW'(in_i.a_x);
      v_q[1] <= DW'(in_i.b_y) - DW'(in_i.a_y);
      v_q[2] <= DW'(in_i.b_z) - DW'(in_i.a_z);
    end
    if (rdy[1] && vld_q[0]) begin
      pr_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
      pr_q[1] <= PW'(u_q[2]) * PW'(v_q[1]);
      pr_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
      pr_q[3] <= PW'(u_q[0]) * PW'(v_q[2]);
      pr_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
      pr_q[5] <= PW'(u_q[1]) * PW'(v_q[0]);
    end
    if (rdy[2] && vld_q[1]) begin
      for (int l = 0; l < LANES; l++) begin
        neg3_q[l] <= n_d[l][NW-1];
        mag_q[l]  <= n_d[l][NW-1] ? MW'(-n_d[l]) : MW'(n_d[l]);
      end
    end
    if (rdy[3] && vld_q[2]) begin
      for (int l = 0; l < LANES; l++) begin
        sq_q[l]   <= SQW'(mag_q[l]) * SQW'(mag_q[l]);
        neg4_q[l] <= neg3_q[l];
      end
    end
    if (rdy[4] && vld_q[3]) begin
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      for (int l = 0; l < LANES; l++) begin
        sq5_q[l]  <= sq_q[l];
        neg5_q[l] <= neg4_q[l];
      end
    end
    if (rdy[5] && vld_q[4]) begin
      s_q   <= RW'(sum_q);
      deg_q <= (sum_q == '0);
      for (int l = 0; l < LANES; l++) begin
        r_q[l]    <= (RW'(sq5_q[l]) <<< (2 * FB + 2)) - RW'(sum_q);
        p_q[l]    <= -RW'(sum_q);
        neg6_q[l] <= neg5_q[l];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign s_o     = s_q;
  assign deg_o   = deg_q;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      r_o[l]   = r_q[l];
      p_o[l]   = p_q[l];
      neg_o[l] = neg6_q[l];
    end
  end

endmodule

FILE: hdl/tun_digit.sv
// ----------------------------------------------------------------------------
// tun_digit
// One bit of the rounded root quotient per lane: trial subtract and update.
// ----------------------------------------------------------------------------
module tun_digit import tun_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 14,
  parameter int K  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [4*CW+2*FB+8:0] r_i [LANES],
  input  logic signed [4*CW+2*FB+8:0] p_i [LANES],
  input  logic signed [4*CW+2*FB+8:0] s_i,
  input  logic        [FB:0]          q_i [LANES],
  input  logic                        neg_i [LANES],
  input  logic                        deg_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [4*CW+2*FB+8:0] r_o [LANES],
  output logic signed [4*CW+2*FB+8:0] p_o [LANES],
  output logic signed [4*CW+2*FB+8:0] s_o,
  output logic        [FB:0]          q_o [LANES],
  output logic                        neg_o [LANES],
  output logic                        deg_o
);

  localparam int RW = 4 * CW + 2 * FB + 9;

  logic                 vld_q;
  logic signed [RW-1:0] dlt [LANES];
  logic                 take [LANES];
  logic signed [RW-1:0] r_d [LANES];
  logic signed [RW-1:0] p_d [LANES];
  logic        [FB:0]   q_d [LANES];

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;

  // y' = y + 2^(K+1): y'^2*S - y^2*S = S*(2^(K+2)*y + 2^(2K+2))
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dlt[l]  = (p_i[l] <<< (K + 2)) + (s_i <<< (2 * K + 2));
      take[l] = (r_i[l] >= dlt[l]);
      r_d[l]  = take[l] ? r_i[l] - dlt[l] : r_i[l];
      p_d[l]  = take[l] ? p_i[l] + (s_i <<< (K + 1)) : p_i[l];
      q_d[l]    = q_i[l];
      q_d[l][K] = take[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      s_o   <= s_i;
      deg_o <= deg_i;
      for (int l = 0; l < LANES; l++) begin
        r_o[l]   <= r_d[l];
        p_o[l]   <= p_d[l];
        q_o[l]   <= q_d[l];
        neg_o[l] <= neg_i[l];
      end
    end
  end

endmodule

FILE: hdl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal (C-A)x(B-A)/|.| of a triangle, signed fixed point out.
//
//   channel  dir  payload                                   transfer
//   in_i     in   a_x..c_z, COORD_WIDTH each                valid & ready
//   out_o    out  normal_x/y/z (16b), degenerate            valid & ready
//
// One transfer per cycle sustained while out_o is not back-pressured; the pipeline is
// six front stages (diffs, products, cross, squares, sum, seed), one stage
// per quotient bit, and the output register.
// Reset clears only the stage valid bits; no state is kept between items.
// Every stage carries its own valid and holds under back-pressure, so bubbles
// close up and a stall drops or repeats nothing.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tun_in_if.sink     in_i,
  tun_out_if.source  out_o
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = NORMAL_FRAC_BITS;
  localparam int RW = 4 * CW + 2 * FB + 9;
  localparam int NS = FB + 1;

  logic                 vld_c [NS+1];
  logic                 rdy_c [NS+1];
  logic signed [RW-1:0] r_c   [NS+1][LANES];
  logic signed [RW-1:0] p_c   [NS+1][LANES];
  logic signed [RW-1:0] s_c   [NS+1];
  logic        [FB:0]   q_c   [NS+1][LANES];
  logic                 neg_c [NS+1][LANES];
  logic                 deg_c [NS+1];

  logic                     out_vld_q;
  logic signed [NORM_W-1:0] nrm_q [LANES];
  logic                     deg_q;
  logic signed [FB+1:0]     qs    [LANES];
  logic signed [NORM_W-1:0] nrm_d [LANES];

  tun_front #(.CW(CW), .FB(FB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (vld_c[0]),
    .ready_i (rdy_c[0]),
    .r_o     (r_c[0]),
    .p_o     (p_c[0]),
    .s_o     (s_c[0]),
    .neg_o   (neg_c[0]),
    .deg_o   (deg_c[0])
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_c[0][l] = '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_digit
    tun_digit #(.CW(CW), .FB(FB), .K(FB - j)) u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[j]),
      .ready_o (rdy_c[j]),
      .r_i     (r_c[j]),
      .p_i     (p_c[j]),
      .s_i     (s_c[j]),
      .q_i     (q_c[j]),
      .neg_i   (neg_c[j]),
      .deg_i   (deg_c[j]),
      .valid_o (vld_c[j+1]),
      .ready_i (rdy_c[j+1]),
      .r_o     (r_c[j+1]),
      .p_o     (p_c[j+1]),
      .s_o     (s_c[j+1]),
      .q_o     (q_c[j+1]),
      .neg_o   (neg_c[j+1]),
      .deg_o   (deg_c[j+1])
    );
  end

  assign rdy_c[NS] = !out_vld_q || out_o.ready;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qs[l]    = $signed({1'b0, q_c[NS][l]});
      nrm_d[l] = deg_c[NS] ? '0 : (neg_c[NS][l] ? NORM_W'(-qs[l]) : NORM_W'(qs[l]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy_c[NS]) begin
      out_vld_q <= vld_c[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c[NS] && vld_c[NS]) begin
      deg_q <= deg_c[NS];
      for (int l = 0; l < LANES; l++) begin
        nrm_q[l] <= nrm_d[l];
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];
  assign out_o.degenerate = deg_q;

  // degenerate result carries a zero vector
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && deg_q |-> nrm_q[0] == '0 && nrm_q[1] == '0 && nrm_q[2] == '0)
    else $error("degenerate result with nonzero normal");

  // input back-pressure only when the output register is full
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_vld_q && !out_o.ready)
    else $error("input stalled with free output register");

  // a new result comes from the last quotient stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(vld_c[NS]))
    else $error("result appeared without a finished item");

  // accepted quotient bits leave a nonnegative lane-0 remainder
  a_rem_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[NS] && q_c[NS][0] != '0 |-> !r_c[NS][0][RW-1])
    else $error("negative remainder after root search");

  a_p_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[NS] && deg_c[NS] |-> p_c[NS][0] == '0 && s_c[NS] == '0)
    else $error("degenerate item with nonzero length sum");

endmodule
